// ----- design/lee_pkg.sv -----
// shared types and constants of the lorenz euler step block
// no dependencies; used by the controller, datapath, multiplier and top level
`default_nettype none

package lee_pkg;

  // width of intermediates and of the product accumulator
  localparam int MID_W  = 64;
  localparam int HALF_W = 32;
  localparam int ACC_W  = 128;

  // intermediates are clipped to [-2^62, 2^62 - 1]
  localparam logic signed [MID_W-1:0] MID_MAX = 64'sh3FFF_FFFF_FFFF_FFFF;
  localparam logic signed [MID_W-1:0] MID_MIN = 64'shC000_0000_0000_0000;
  localparam logic [ACC_W-1:0] MID_LIM = ACC_W'(1) << 62;

  typedef enum logic [1:0] {
    CMD_STEP   = 2'd0,
    CMD_LOAD_X = 2'd1,
    CMD_LOAD_Y = 2'd2,
    CMD_LOAD_Z = 2'd3
  } cmd_t;

  // product schedule of one euler step
  typedef enum logic [2:0] {
    OP_HA = 3'd0,  // h * sigma
    OP_XR = 3'd1,  // x * (rho - z)
    OP_HY = 3'd2,  // h * (x*(rho - z) - y)
    OP_XY = 3'd3,  // x * y
    OP_CZ = 3'd4,  // beta * z
    OP_HZ = 3'd5,  // h * (x*y - beta*z)
    OP_HX = 3'd6   // (h*sigma) * (y - x)
  } op_t;

  localparam op_t OP_FIRST = OP_HA;
  localparam op_t OP_LAST  = OP_HX;

  typedef struct packed {
    logic capture;
    logic mul_start;
    op_t  op;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic mul_done;
  } dp_sts_t;

endpackage

`default_nettype wire

// ----- design/lee_mulq.sv -----
// multi-cycle fixed-point multiplier: 64x64 signed product from four 32x32
// partial products, floor shift by FRAC_BITS and clip to [-2^62, 2^62 - 1]; uses lee_pkg
`default_nettype none

module lee_mulq #(
  parameter int FRAC_BITS = 24
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  input  wire logic signed [lee_pkg::MID_W-1:0]   opa,
  input  wire logic signed [lee_pkg::MID_W-1:0]   opb,
  output logic                                    done,
  output logic signed [lee_pkg::MID_W-1:0]        res,
  output logic                                    clip
);

  typedef enum logic [1:0] {
    M_IDLE,
    M_ACC,
    M_POST
  } mstate_t;

  mstate_t                           st_r, st_nxt;
  logic [1:0]                        cnt_r, cnt_nxt;
  logic                              neg_r;
  logic [lee_pkg::MID_W-1:0]         ma_r, mb_r;
  logic [lee_pkg::ACC_W-1:0]         acc_r, acc_nxt;
  logic                              done_r, done_nxt;
  logic signed [lee_pkg::MID_W-1:0]  res_r, res_nxt;
  logic                              clip_r, clip_nxt;

  logic [lee_pkg::MID_W-1:0]         mag_a, mag_b;
  logic [lee_pkg::HALF_W-1:0]        a_half, b_half;
  logic [lee_pkg::MID_W-1:0]         pp;
  logic [1:0]                        sh;
  logic [lee_pkg::ACC_W-1:0]         pp_w;
  logic [lee_pkg::ACC_W-1:0]         q, q_inc;
  logic                              rem_nz;

  assign mag_a = opa[lee_pkg::MID_W-1] ? lee_pkg::MID_W'(-opa) : lee_pkg::MID_W'(opa);
  assign mag_b = opb[lee_pkg::MID_W-1] ? lee_pkg::MID_W'(-opb) : lee_pkg::MID_W'(opb);

  // partial product: cnt bit 0 picks the half of a, bit 1 the half of b
  assign a_half = cnt_r[0] ? ma_r[lee_pkg::MID_W-1:lee_pkg::HALF_W]
                           : ma_r[lee_pkg::HALF_W-1:0];
  assign b_half = cnt_r[1] ? mb_r[lee_pkg::MID_W-1:lee_pkg::HALF_W]
                           : mb_r[lee_pkg::HALF_W-1:0];
  assign pp     = a_half * b_half;
  assign sh     = {1'b0, cnt_r[0]} + {1'b0, cnt_r[1]};
  assign pp_w   = lee_pkg::ACC_W'(pp) << {sh, 5'b0};

  // floor shift of the signed product
  assign q      = acc_r >> FRAC_BITS;
  assign rem_nz = |acc_r[FRAC_BITS-1:0];
  assign q_inc  = q + lee_pkg::ACC_W'(neg_r & rem_nz);

  always_comb begin
    st_nxt   = st_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    done_nxt = 1'b0;
    res_nxt  = res_r;
    clip_nxt = clip_r;
    case (st_r)
      M_IDLE: begin
        if (start) begin
          st_nxt  = M_ACC;
          cnt_nxt = 2'd0;
          acc_nxt = '0;
        end
      end
      M_ACC: begin
        acc_nxt = acc_r + pp_w;
        cnt_nxt = cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          st_nxt = M_POST;
        end
      end
      M_POST: begin
        st_nxt   = M_IDLE;
        done_nxt = 1'b1;
        if (neg_r) begin
          clip_nxt = q_inc > lee_pkg::MID_LIM;
          res_nxt  = clip_nxt ? lee_pkg::MID_MIN
                              : -$signed(q_inc[lee_pkg::MID_W-1:0]);
        end else begin
          clip_nxt = q_inc > (lee_pkg::MID_LIM - lee_pkg::ACC_W'(1));
          res_nxt  = clip_nxt ? lee_pkg::MID_MAX
                              : $signed(q_inc[lee_pkg::MID_W-1:0]);
        end
      end
      default: begin
        st_nxt = M_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= M_IDLE;
      cnt_r  <= 2'd0;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == M_IDLE && start) begin
      ma_r  <= mag_a;
      mb_r  <= mag_b;
      neg_r <= opa[lee_pkg::MID_W-1] ^ opb[lee_pkg::MID_W-1];
    end
    acc_r  <= acc_nxt;
    res_r  <= res_nxt;
    clip_r <= clip_nxt;
  end

  assign done = done_r;
  assign res  = res_r;
  assign clip = clip_r;

endmodule

`default_nettype wire

// ----- design/lee_dpath.sv -----
// datapath: item capture, state registers, operand select, shared multiplier
// and final clip; uses lee_pkg and lee_mulq
`default_nettype none

module lee_dpath #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 24
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire lee_pkg::dp_cmd_t             cmd,
  output lee_pkg::dp_sts_t                  sts,
  input  wire logic [1:0]                   in_command,
  input  wire logic signed [DATA_WIDTH-1:0] in_step_size,
  input  wire logic signed [DATA_WIDTH-1:0] in_sigma,
  input  wire logic signed [DATA_WIDTH-1:0] in_rho,
  input  wire logic signed [DATA_WIDTH-1:0] in_beta,
  input  wire logic signed [DATA_WIDTH-1:0] in_load_value,
  output logic signed [DATA_WIDTH-1:0]      out_x,
  output logic signed [DATA_WIDTH-1:0]      out_y,
  output logic signed [DATA_WIDTH-1:0]      out_z,
  output logic                              out_saturated
);

  localparam int MW = lee_pkg::MID_W;
  localparam logic [MW-1:0] INIT_X = ((64'd1 << FRAC_BITS) + 64'd5) / 64'd10;
  localparam logic signed [MW-1:0] DW_MAX = MW'((64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1);
  localparam logic signed [MW-1:0] DW_MIN = -DW_MAX - 64'sd1;

  // returns {clipped, value}
  function automatic logic [DATA_WIDTH:0] clip_dw(input logic signed [MW-1:0] v);
    logic [DATA_WIDTH:0] r;
    if (v > DW_MAX) begin
      r = {1'b1, DW_MAX[DATA_WIDTH-1:0]};
    end else if (v < DW_MIN) begin
      r = {1'b1, DW_MIN[DATA_WIDTH-1:0]};
    end else begin
      r = {1'b0, v[DATA_WIDTH-1:0]};
    end
    return r;
  endfunction

  lee_pkg::cmd_t                  cmd_r;
  logic signed [DATA_WIDTH-1:0]   h_r, sig_r, rho_r, beta_r, ld_r;
  logic signed [DATA_WIDTH-1:0]   x_r, y_r, z_r;
  logic                           sat_r, mid_sat_r;
  logic signed [MW-1:0]           t_ha_r, t_a_r, t_b_r, t_c_r, dx_r, dy_r, dz_r;

  logic signed [MW-1:0]           h64, sig64, rho64, beta64, x64, y64, z64;
  logic signed [MW-1:0]           opa, opb, mres;
  logic                           mdone, mclip;
  logic [DATA_WIDTH:0]            cx, cy, cz;

  assign h64    = MW'(h_r);
  assign sig64  = MW'(sig_r);
  assign rho64  = MW'(rho_r);
  assign beta64 = MW'(beta_r);
  assign x64    = MW'(x_r);
  assign y64    = MW'(y_r);
  assign z64    = MW'(z_r);

  always_comb begin
    case (cmd.op)
      lee_pkg::OP_HA: begin opa = h64;    opb = sig64;         end
      lee_pkg::OP_XR: begin opa = x64;    opb = rho64 - z64;   end
      lee_pkg::OP_HY: begin opa = h64;    opb = t_a_r - y64;   end
      lee_pkg::OP_XY: begin opa = x64;    opb = y64;           end
      lee_pkg::OP_CZ: begin opa = beta64; opb = z64;           end
      lee_pkg::OP_HZ: begin opa = h64;    opb = t_b_r - t_c_r; end
      lee_pkg::OP_HX: begin opa = t_ha_r; opb = y64 - x64;     end
      default:        begin opa = '0;     opb = '0;            end
    endcase
  end

  lee_mulq #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mulq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mul_start),
    .opa   (opa),
    .opb   (opb),
    .done  (mdone),
    .res   (mres),
    .clip  (mclip)
  );

  assign sts.mul_done = mdone;

  assign cx = clip_dw(x64 + dx_r);
  assign cy = clip_dw(y64 + dy_r);
  assign cz = clip_dw(z64 + dz_r);

  // captured item and product results
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r  <= lee_pkg::cmd_t'(in_command);
      h_r    <= in_step_size;
      sig_r  <= in_sigma;
      rho_r  <= in_rho;
      beta_r <= in_beta;
      ld_r   <= in_load_value;
    end
    if (mdone) begin
      case (cmd.op)
        lee_pkg::OP_HA: t_ha_r <= mres;
        lee_pkg::OP_XR: t_a_r  <= mres;
        lee_pkg::OP_HY: dy_r   <= mres;
        lee_pkg::OP_XY: t_b_r  <= mres;
        lee_pkg::OP_CZ: t_c_r  <= mres;
        lee_pkg::OP_HZ: dz_r   <= mres;
        lee_pkg::OP_HX: dx_r   <= mres;
        default: ;
      endcase
    end
    if (cmd.capture) begin
      mid_sat_r <= 1'b0;
    end else if (mdone && mclip) begin
      mid_sat_r <= 1'b1;
    end
  end

  // oscillator state, updated only when a result is committed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r   <= INIT_X[DATA_WIDTH-1:0];
      y_r   <= '0;
      z_r   <= '0;
      sat_r <= 1'b0;
    end else if (cmd.commit) begin
      case (cmd_r)
        lee_pkg::CMD_STEP: begin
          x_r   <= cx[DATA_WIDTH-1:0];
          y_r   <= cy[DATA_WIDTH-1:0];
          z_r   <= cz[DATA_WIDTH-1:0];
          sat_r <= mid_sat_r | cx[DATA_WIDTH] | cy[DATA_WIDTH] | cz[DATA_WIDTH];
        end
        lee_pkg::CMD_LOAD_X: begin
          x_r   <= ld_r;
          sat_r <= 1'b0;
        end
        lee_pkg::CMD_LOAD_Y: begin
          y_r   <= ld_r;
          sat_r <= 1'b0;
        end
        lee_pkg::CMD_LOAD_Z: begin
          z_r   <= ld_r;
          sat_r <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  assign out_x         = x_r;
  assign out_y         = y_r;
  assign out_z         = z_r;
  assign out_saturated = sat_r;

endmodule

`default_nettype wire

// ----- design/lee_ctrl.sv -----
// controller: handshakes and product schedule of one euler step
// uses lee_pkg; drives the datapath through lee_pkg::dp_cmd_t
`default_nettype none

module lee_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        in_command,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output lee_pkg::dp_cmd_t       cmd,
  input  wire lee_pkg::dp_sts_t  sts
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_COMMIT
  } state_t;

  state_t         st_r, st_nxt;
  lee_pkg::op_t   op_r, op_nxt;
  logic           start_r, start_nxt;
  logic           stall_r, stall_nxt;
  logic           ovalid_r, ovalid_nxt;
  logic           accept, out_free, commit;

  assign accept   = in_valid && !stall_r;
  assign out_free = !ovalid_r || !out_stall;
  assign commit   = (st_r == S_COMMIT) && out_free;

  always_comb begin
    st_nxt    = st_r;
    op_nxt    = op_r;
    start_nxt = 1'b0;
    case (st_r)
      S_IDLE: begin
        if (accept) begin
          if (lee_pkg::cmd_t'(in_command) == lee_pkg::CMD_STEP) begin
            st_nxt    = S_MUL;
            op_nxt    = lee_pkg::OP_FIRST;
            start_nxt = 1'b1;
          end else begin
            st_nxt = S_COMMIT;
          end
        end
      end
      S_MUL: begin
        if (sts.mul_done) begin
          if (op_r == lee_pkg::OP_LAST) begin
            st_nxt = S_COMMIT;
          end else begin
            op_nxt    = lee_pkg::op_t'(op_r + 3'd1);
            start_nxt = 1'b1;
          end
        end
      end
      S_COMMIT: begin
        if (out_free) begin
          st_nxt = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
    stall_nxt  = (st_nxt != S_IDLE);
    ovalid_nxt = commit ? 1'b1 : (ovalid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= S_IDLE;
      op_r     <= lee_pkg::OP_FIRST;
      start_r  <= 1'b0;
      stall_r  <= 1'b1;
      ovalid_r <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      op_r     <= op_nxt;
      start_r  <= start_nxt;
      stall_r  <= stall_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  assign in_stall      = stall_r;
  assign out_valid     = ovalid_r;
  assign cmd.capture   = accept;
  assign cmd.mul_start = start_r;
  assign cmd.op        = op_r;
  assign cmd.commit    = commit;

endmodule

`default_nettype wire

// ----- design/lorenz_euler_step.sv -----
// lorenz euler step: chaotic oscillator advanced one forward euler step per item
// top level; uses lee_pkg, lee_ctrl, lee_dpath (with lee_mulq)
//
// usage
//   input channel in_*: one item per command. a step item (command 0) takes
//   step_size, sigma, rho and beta and moves the stored point (x, y, z);
//   a load item (commands 1..3) overwrites x, y or z with in_load_value.
//   an item is taken at a clock edge with in_valid high and in_stall low.
//   output channel out_*: one item per input item, the point after it plus
//   a saturated flag, taken at an edge with out_valid high, out_stall low.
// step and load sequence
//   a step runs seven products through one shared multiplier; each product
//   passes operand latch, four 32x32 partial products, floor/clip and
//   hand-back. a load goes from acceptance through the commit state to the
//   output register. a new item is taken the cycle after the previous
//   result is committed to the output register.
// reset and stall
//   synchronous active-low reset puts x at 0.1 in the fixed-point format,
//   y and z at zero; in_stall is high for one cycle after reset.
//   while the output is stalled the next item may still be accepted and
//   computed; it waits in commit until the pending result is taken
`default_nettype none

module lorenz_euler_step #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 24
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // input channel
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [1:0]                   in_command,
  input  wire logic signed [DATA_WIDTH-1:0] in_step_size,
  input  wire logic signed [DATA_WIDTH-1:0] in_sigma,
  input  wire logic signed [DATA_WIDTH-1:0] in_rho,
  input  wire logic signed [DATA_WIDTH-1:0] in_beta,
  input  wire logic signed [DATA_WIDTH-1:0] in_load_value,
  // result channel
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic signed [DATA_WIDTH-1:0]      out_x,
  output logic signed [DATA_WIDTH-1:0]      out_y,
  output logic signed [DATA_WIDTH-1:0]      out_z,
  output logic                              out_saturated
);

  lee_pkg::dp_cmd_t dp_cmd;
  lee_pkg::dp_sts_t dp_sts;

  // sequencing and handshakes
  lee_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_command (in_command),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .cmd        (dp_cmd),
    .sts        (dp_sts)
  );

  // state, operand mux, shared multiplier; state registers drive the outputs
  // directly since they only change when a result is committed
  lee_dpath #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (dp_cmd),
    .sts           (dp_sts),
    .in_command    (in_command),
    .in_step_size  (in_step_size),
    .in_sigma      (in_sigma),
    .in_rho        (in_rho),
    .in_beta       (in_beta),
    .in_load_value (in_load_value),
    .out_x         (out_x),
    .out_y         (out_y),
    .out_z         (out_z),
    .out_saturated (out_saturated)
  );

  // a result appears only out of a busy phase
  a_valid_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result raised without an item in flight");

  // the commit that raises out_valid also releases the input
  a_commit_releases: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !in_stall)
    else $error("input not released at commit");

  // the point only moves at a commit, which happens while busy
  a_state_moves_at_commit: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (out_x != $past(out_x))) |-> $past(in_stall))
    else $error("state changed outside a commit");

endmodule

`default_nettype wire

// ----- tb/sv/tb_lorenz_euler_step.sv -----
// testbench of the lorenz euler step block: directed and random step and load items,
// every result checked against a fixed-point predictor of the euler step kept here
// depends on lee_pkg (command codes) and the lorenz_euler_step top level
`default_nettype none

module tb_lorenz_euler_step;
  import lee_pkg::*;

  localparam int DW = 32;
  localparam int FB = 24;

  // x after reset is 0.1 in q8.24
  localparam logic signed [DW-1:0] X_AT_RESET = 32'sd1677722;
  localparam logic signed [DW-1:0] W_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DW-1:0] W_MIN = 32'sh8000_0000;
  // products are clipped to [-2^62, 2^62 - 1]
  localparam logic signed [63:0] PROD_HI = 64'sh3FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] PROD_LO = 64'shC000_0000_0000_0000;

  // 1170 items with worst gaps and stalls stay far below this cycle limit
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 80;
  localparam int REPORT_LIMIT = 10;

  typedef struct {
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic signed [DW-1:0] z;
    logic                 sat;
  } point_t;

  // clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always #5 clk = ~clk;

  // input channel, driven from time zero
  logic                 in_valid      = 1'b0;
  logic                 in_stall;
  logic [1:0]           in_command    = CMD_STEP;
  logic signed [DW-1:0] in_step_size  = '0;
  logic signed [DW-1:0] in_sigma      = '0;
  logic signed [DW-1:0] in_rho        = '0;
  logic signed [DW-1:0] in_beta       = '0;
  logic signed [DW-1:0] in_load_value = '0;

  // result channel
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic signed [DW-1:0] out_x;
  logic signed [DW-1:0] out_y;
  logic signed [DW-1:0] out_z;
  logic                 out_saturated;

  lorenz_euler_step #(
    .DATA_WIDTH(DW),
    .FRAC_BITS (FB)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_command   (in_command),
    .in_step_size (in_step_size),
    .in_sigma     (in_sigma),
    .in_rho       (in_rho),
    .in_beta      (in_beta),
    .in_load_value(in_load_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_x        (out_x),
    .out_y        (out_y),
    .out_z        (out_z),
    .out_saturated(out_saturated)
  );

  // predicted point of the attractor, same reset as the block
  logic signed [DW-1:0] pt_x = X_AT_RESET;
  logic signed [DW-1:0] pt_y = '0;
  logic signed [DW-1:0] pt_z = '0;
  bit                   clip_hit;

  // points still owed by the block, oldest first
  point_t pending_points[$];

  int  mismatch_count = 0;
  int  result_count   = 0;
  int  cycle_count    = 0;
  int  rx_hold        = 0;
  // random idling on both sides; off for the tail of the run
  bit  idle_on        = 1'b1;

  // fixed-point product: exact, floored by the fraction shift, then clipped
  function automatic logic signed [63:0] fx_mul(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
    logic signed [127:0] wa;
    logic signed [127:0] wb;
    logic signed [127:0] prod;
    wa   = a;
    wb   = b;
    prod = (wa * wb) >>> FB;
    if (prod > PROD_HI) begin
      clip_hit = 1'b1;
      return PROD_HI;
    end
    if (prod < PROD_LO) begin
      clip_hit = 1'b1;
      return PROD_LO;
    end
    return prod[63:0];
  endfunction

  // new coordinate clipped into the word range
  function automatic logic signed [DW-1:0] fit_word(input logic signed [63:0] v);
    if (v > W_MAX) begin
      clip_hit = 1'b1;
      return W_MAX;
    end
    if (v < W_MIN) begin
      clip_hit = 1'b1;
      return W_MIN;
    end
    return v[DW-1:0];
  endfunction

  // advance the predicted point by one item and queue the point it yields
  task automatic advance_point(input cmd_t cmd, input logic signed [DW-1:0] h,
                               input logic signed [DW-1:0] sg,
                               input logic signed [DW-1:0] rh,
                               input logic signed [DW-1:0] bt,
                               input logic signed [DW-1:0] lv);
    logic signed [63:0] x0, y0, z0, hw, sw, rw, bw, x1, y1, z1;
    point_t p;
    clip_hit = 1'b0;
    case (cmd)
      CMD_STEP: begin
        x0 = pt_x;
        y0 = pt_y;
        z0 = pt_z;
        hw = h;
        sw = sg;
        rw = rh;
        bw = bt;
        // forward euler on all three coordinates from the old point
        x1 = x0 + fx_mul(fx_mul(hw, sw), y0 - x0);
        y1 = y0 + fx_mul(hw, fx_mul(x0, rw - z0) - y0);
        z1 = z0 + fx_mul(hw, fx_mul(x0, y0) - fx_mul(bw, z0));
        pt_x = fit_word(x1);
        pt_y = fit_word(y1);
        pt_z = fit_word(z1);
      end
      CMD_LOAD_X: pt_x = lv;
      CMD_LOAD_Y: pt_y = lv;
      default:    pt_z = lv;
    endcase
    p.x   = pt_x;
    p.y   = pt_y;
    p.z   = pt_z;
    p.sat = clip_hit;
    pending_points.push_back(p);
  endtask

  // drive one item and hold it until the block takes it
  task automatic send_item(input cmd_t cmd, input logic signed [DW-1:0] h,
                           input logic signed [DW-1:0] sg,
                           input logic signed [DW-1:0] rh,
                           input logic signed [DW-1:0] bt,
                           input logic signed [DW-1:0] lv);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      // sometimes let the gap fall while the block is ready for an item
      if ($urandom_range(0, 1) == 1) begin
        while (in_stall) @(posedge clk);
      end
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_command    <= cmd;
    in_step_size  <= h;
    in_sigma      <= sg;
    in_rho        <= rh;
    in_beta       <= bt;
    in_load_value <= lv;
    // values seen right after the edge are the ones the block saw at the edge
    do @(posedge clk); while (in_stall);
    advance_point(cmd, h, sg, rh, bt, lv);
  endtask

  function automatic logic signed [DW-1:0] to_q(input real r);
    return $rtoi(r * 16777216.0);
  endfunction

  // mostly the corner values, otherwise plain random words
  function automatic logic signed [DW-1:0] edgy_word();
    case ($urandom_range(0, 7))
      0:       return W_MAX;
      1:       return W_MIN;
      2:       return '0;
      3:       return -32'sd1;
      4:       return 32'sd1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [DW-1:0] rand_between(input int lo, input int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  // classic parameters from the reset point, then a zero step
  task automatic test_reset_point();
    send_item(CMD_STEP, to_q(0.01), to_q(10.0), to_q(28.0), to_q(8.0 / 3.0), W_MAX);
    send_item(CMD_STEP, '0, to_q(10.0), to_q(28.0), to_q(8.0 / 3.0), W_MIN);
  endtask

  // each load command, with the word extremes among the values
  task automatic test_load_commands();
    send_item(CMD_LOAD_X, W_MIN, W_MAX, W_MIN, W_MAX, W_MAX);
    send_item(CMD_LOAD_Y, W_MAX, W_MIN, W_MAX, W_MIN, W_MIN);
    send_item(CMD_LOAD_Z, '0, '0, '0, '0, -32'sd1);
    send_item(CMD_LOAD_X, -32'sd1, -32'sd1, -32'sd1, -32'sd1, '0);
    send_item(CMD_LOAD_X, '0, '0, '0, '0, to_q(1.5));
    send_item(CMD_LOAD_Y, '0, '0, '0, '0, to_q(-2.25));
    send_item(CMD_LOAD_Z, '0, '0, '0, '0, to_q(20.0));
  endtask

  // negative products whose floor differs from truncation
  task automatic test_rounding_steps();
    send_item(CMD_STEP, to_q(-0.01), to_q(10.0), to_q(28.0), to_q(8.0 / 3.0), '0);
    send_item(CMD_STEP, -32'sd1, 32'sd1, -32'sd1, 32'sd1, '0);
    send_item(CMD_STEP, to_q(0.001), to_q(-3.3), to_q(-7.7), to_q(-1.1), '0);
  endtask

  // huge steps from corner points, where coordinates clip, and a zero step
  task automatic test_saturation_steps();
    send_item(CMD_LOAD_X, '0, '0, '0, '0, W_MAX);
    send_item(CMD_LOAD_Y, '0, '0, '0, '0, W_MIN);
    send_item(CMD_LOAD_Z, '0, '0, '0, '0, W_MAX);
    send_item(CMD_STEP, W_MAX, W_MAX, W_MIN, W_MAX, W_MAX);
    send_item(CMD_STEP, W_MIN, W_MIN, W_MAX, W_MIN, W_MIN);
    send_item(CMD_STEP, '0, '0, '0, '0, '0);
    send_item(CMD_LOAD_X, '0, '0, '0, '0, W_MIN);
    send_item(CMD_STEP, W_MAX, W_MIN, W_MAX, W_MIN, -32'sd1);
  endtask

  // mostly trajectories with sane parameters, plus loads and noise
  task automatic test_random_items(input int count);
    int   pick;
    cmd_t cmd;
    logic signed [DW-1:0] h;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      cmd  = cmd_t'($urandom_range(1, 3));
      if (pick < 15) begin
        send_item(cmd, $urandom, $urandom, $urandom, $urandom,
                  rand_between(-671088640, 671088640));
      end else if (pick < 20) begin
        send_item(cmd, $urandom, $urandom, $urandom, $urandom, edgy_word());
      end else if (pick < 75) begin
        if ($urandom_range(0, 9) == 0) h = rand_between(-int'(to_q(0.02)), 0);
        else h = rand_between(0, to_q(0.05));
        send_item(CMD_STEP, h, rand_between(0, to_q(20.0)), rand_between(0, to_q(50.0)),
                  rand_between(0, to_q(6.0)), $urandom);
      end else if (pick < 90) begin
        send_item(CMD_STEP, edgy_word(), edgy_word(), edgy_word(), edgy_word(),
                  edgy_word());
      end else begin
        send_item(cmd_t'($urandom_range(0, 3)), $urandom, $urandom, $urandom, $urandom,
                  $urandom);
      end
    end
  endtask

  // back-to-back items with no idling on either side
  task automatic test_quiet_tail(input int count);
    idle_on = 1'b0;
    test_random_items(count);
  endtask

  // result side: random stall bursts and the check of each result taken
  always @(posedge clk) begin
    point_t p;
    if (rst_n && out_valid && !out_stall) begin
      result_count++;
      if (pending_points.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("unexpected result %0d: x %h y %h z %h sat %b", result_count,
                   out_x, out_y, out_z, out_saturated);
      end else begin
        p = pending_points.pop_front();
        if (out_x !== p.x || out_y !== p.y || out_z !== p.z ||
            out_saturated !== p.sat) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("mismatch on result %0d: x exp %h got %h, y exp %h got %h, ",
                     result_count, p.x, out_x, p.y, out_y,
                     "z exp %h got %h, sat exp %b got %b",
                     p.z, out_z, p.sat, out_saturated);
        end
      end
    end
    // stall bursts of random length
    if (rx_hold > 0) begin
      rx_hold--;
      out_stall <= 1'b1;
    end else if (idle_on && rst_n && $urandom_range(0, 7) == 0) begin
      rx_hold = $urandom_range(0, 2);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_point();
    test_load_commands();
    test_rounding_steps();
    test_saturation_steps();
    test_random_items(1000);
    test_quiet_tail(150);
    in_valid <= 1'b0;
    // drain, then give stray results time to show up
    while (pending_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_points.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
